[src/imufr_pkg.sv]
// ----------------------------------------------------------------------------
// imufr_pkg: shared types and constants of the IMU frame rotation block
// Holds the transaction structs of the request and response channels, the
// register indexes of the control port and the fixed-point constants.
// ----------------------------------------------------------------------------
package imufr_pkg;

   // Register indexes of the control port.
   localparam logic [1:0] CSR_MOUNT_W = 2'd0;
   localparam logic [1:0] CSR_MOUNT_X = 2'd1;
   localparam logic [1:0] CSR_MOUNT_Y = 2'd2;
   localparam logic [1:0] CSR_MOUNT_Z = 2'd3;

   // Unit value of a Q1.14 quaternion part.
   localparam logic signed [15:0] Q_ONE = 16'sd16384;
   localparam logic signed [15:0] Q_MINUS_ONE = -16'sd16384;

   // Unit value of a Q2.28 rotation matrix entry.
   localparam logic signed [31:0] R_ONE = 32'sd268435456;

   // Half of one output LSB after the right shift by 28.
   localparam logic signed [63:0] VEC_HALF = 64'sd134217728;
   localparam logic signed [47:0] QUAT_HALF = 48'sd134217728;

   // Request transaction: one IMU sample in the sensor frame.
   typedef struct packed {
      logic [31:0]        stamp;
      logic signed [31:0] gyro_x;
      logic signed [31:0] gyro_y;
      logic signed [31:0] gyro_z;
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
      logic signed [31:0] accel_z;
      logic signed [15:0] orient_w;
      logic signed [15:0] orient_x;
      logic signed [15:0] orient_y;
      logic signed [15:0] orient_z;
   } imufr_req_type;

   // Response transaction: the same sample in the body frame.
   typedef struct packed {
      logic [31:0]        out_stamp;
      logic signed [31:0] out_gyro_x;
      logic signed [31:0] out_gyro_y;
      logic signed [31:0] out_gyro_z;
      logic signed [31:0] out_accel_x;
      logic signed [31:0] out_accel_y;
      logic signed [31:0] out_accel_z;
      logic signed [15:0] out_orient_w;
      logic signed [15:0] out_orient_x;
      logic signed [15:0] out_orient_y;
      logic signed [15:0] out_orient_z;
   } imufr_rsp_type;

endpackage

[src/imu_frame_rotation.sv]
// ----------------------------------------------------------------------------
// imu_frame_rotation: IMU sample rotation from sensor frame to body frame
// Rotates the angular rate and acceleration vectors by a mounting quaternion
// and conjugates the sample orientation with it, in a five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   The mounting quaternion is written through the csr_ port (csr_we,
//   csr_index, csr_wdata); write it only while no transaction is in flight.
//   A request transaction is taken at a rising edge with start high and busy
//   low. busy is always low: the pipeline takes one sample every cycle.
//   The response appears with rsp_valid high for exactly one cycle, after
//   the accepted sample has passed the input register, the product
//   stage, the matrix stage, the second product stage and the output
//   register. A new sample can enter on every edge, so responses come out
//   back to back in request order.
//   The receiver cannot hold responses off and none is needed: the pipeline
//   never stalls. Throughput is set by the multiplier stages, one per cycle.
//   Reset flushes every valid bit in the pipeline and sets the mount to the
//   identity quaternion, so that samples pass through unrotated.
// ----------------------------------------------------------------------------
module imu_frame_rotation (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  imufr_pkg::imufr_req_type req_data,
   output logic                     rsp_valid,
   output imufr_pkg::imufr_rsp_type rsp_data,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_wdata
);

   // Clamp a quaternion part to [-1, 1] in Q1.14.
   function automatic logic signed [15:0] clamp_q(input logic signed [15:0] v);
      logic signed [15:0] r;
      r = v;
      if (v > imufr_pkg::Q_ONE) r = imufr_pkg::Q_ONE;
      if (v < imufr_pkg::Q_MINUS_ONE) r = imufr_pkg::Q_MINUS_ONE;
      return r;
   endfunction

   // Round a Q18.44 vector sum to Q16.16 and saturate to 32 bits.
   function automatic logic signed [31:0] round_vec(input logic signed [63:0] v);
      logic signed [63:0] t;
      logic signed [35:0] s;
      logic signed [31:0] r;
      t = v + imufr_pkg::VEC_HALF;
      s = 36'(t >>> 28);
      r = s[31:0];
      if (s > 36'sh07FFFFFFF) r = 32'sh7FFFFFFF;
      if (s < -36'sh080000000) r = 32'sh80000000;
      return r;
   endfunction

   // Round a Q3.42 quaternion sum to Q1.14 and saturate to [-1, 1].
   function automatic logic signed [15:0] round_quat(input logic signed [47:0] v);
      logic signed [47:0] t;
      logic signed [19:0] s;
      logic signed [15:0] r;
      t = v + imufr_pkg::QUAT_HALF;
      s = 20'(t >>> 28);
      r = s[15:0];
      if (s > 20'sd16384) r = imufr_pkg::Q_ONE;
      if (s < -20'sd16384) r = imufr_pkg::Q_MINUS_ONE;
      return r;
   endfunction

   // Mount registers and their clamped view (0 = w, 1 = x, 2 = y, 3 = z).
   logic signed [15:0] mount_ff [4];
   logic signed [15:0] mount_in [4];
   logic signed [15:0] m [4];

   // Stage 0: input register with clamped orientation.
   logic               s0_valid_ff, s0_valid_in;
   logic [31:0]        s0_stamp_ff, s0_stamp_in;
   logic signed [31:0] s0_gyro_ff [3];
   logic signed [31:0] s0_gyro_in [3];
   logic signed [31:0] s0_accel_ff [3];
   logic signed [31:0] s0_accel_in [3];
   logic signed [15:0] s0_q_ff [4];
   logic signed [15:0] s0_q_in [4];

   // Stage 1: mount self products and mount-by-orientation products.
   logic               s1_valid_ff, s1_valid_in;
   logic [31:0]        s1_stamp_ff, s1_stamp_in;
   logic signed [31:0] s1_gyro_ff [3];
   logic signed [31:0] s1_gyro_in [3];
   logic signed [31:0] s1_accel_ff [3];
   logic signed [31:0] s1_accel_in [3];
   logic signed [31:0] s1_xx_ff, s1_yy_ff, s1_zz_ff, s1_xy_ff, s1_xz_ff;
   logic signed [31:0] s1_yz_ff, s1_xw_ff, s1_yw_ff, s1_zw_ff;
   logic signed [31:0] s1_xx_in, s1_yy_in, s1_zz_in, s1_xy_in, s1_xz_in;
   logic signed [31:0] s1_yz_in, s1_xw_in, s1_yw_in, s1_zw_in;
   logic signed [31:0] s1_mq_ff [4][4];
   logic signed [31:0] s1_mq_in [4][4];

   // Stage 2: rotation matrix and the product p = m * q.
   logic               s2_valid_ff, s2_valid_in;
   logic [31:0]        s2_stamp_ff, s2_stamp_in;
   logic signed [31:0] s2_gyro_ff [3];
   logic signed [31:0] s2_gyro_in [3];
   logic signed [31:0] s2_accel_ff [3];
   logic signed [31:0] s2_accel_in [3];
   logic signed [31:0] s2_rm_ff [3][3];
   logic signed [31:0] s2_rm_in [3][3];
   logic signed [31:0] s2_p_ff [4];
   logic signed [31:0] s2_p_in [4];

   // Stage 3: matrix-by-vector products and p-by-mount products.
   logic               s3_valid_ff, s3_valid_in;
   logic [31:0]        s3_stamp_ff, s3_stamp_in;
   logic signed [63:0] s3_gp_ff [3][3];
   logic signed [63:0] s3_gp_in [3][3];
   logic signed [63:0] s3_ap_ff [3][3];
   logic signed [63:0] s3_ap_in [3][3];
   logic signed [47:0] s3_pm_ff [4][4];
   logic signed [47:0] s3_pm_in [4][4];

   // Stage 4: output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   imufr_pkg::imufr_rsp_type rsp_data_ff, rsp_data_in;

   logic signed [63:0] gsum [3];
   logic signed [63:0] asum [3];
   logic signed [47:0] osum [4];

   // The pipeline never stalls, so a request is always taken.
   assign busy = 1'b0;

   // Mount register writes.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mount_in[i] = mount_ff[i];
      end
      if (csr_we) begin
         unique case (csr_index)
            imufr_pkg::CSR_MOUNT_W: mount_in[0] = csr_wdata;
            imufr_pkg::CSR_MOUNT_X: mount_in[1] = csr_wdata;
            imufr_pkg::CSR_MOUNT_Y: mount_in[2] = csr_wdata;
            imufr_pkg::CSR_MOUNT_Z: mount_in[3] = csr_wdata;
         endcase
      end
      for (int i = 0; i < 4; i++) begin
         m[i] = clamp_q(mount_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mount_ff[0] <= imufr_pkg::Q_ONE;
         mount_ff[1] <= '0;
         mount_ff[2] <= '0;
         mount_ff[3] <= '0;
      end else begin
         mount_ff <= mount_in;
      end
   end

   // Stage 0: capture the request and clamp the orientation.
   always_comb begin
      s0_valid_in    = start && !busy;
      s0_stamp_in    = req_data.stamp;
      s0_gyro_in[0]  = req_data.gyro_x;
      s0_gyro_in[1]  = req_data.gyro_y;
      s0_gyro_in[2]  = req_data.gyro_z;
      s0_accel_in[0] = req_data.accel_x;
      s0_accel_in[1] = req_data.accel_y;
      s0_accel_in[2] = req_data.accel_z;
      s0_q_in[0]     = clamp_q(req_data.orient_w);
      s0_q_in[1]     = clamp_q(req_data.orient_x);
      s0_q_in[2]     = clamp_q(req_data.orient_y);
      s0_q_in[3]     = clamp_q(req_data.orient_z);
   end

   // Stage 1: one 16x16 multiply per product.
   always_comb begin
      s1_valid_in = s0_valid_ff;
      s1_stamp_in = s0_stamp_ff;
      s1_gyro_in  = s0_gyro_ff;
      s1_accel_in = s0_accel_ff;
      s1_xx_in    = 32'(m[1]) * 32'(m[1]);
      s1_yy_in    = 32'(m[2]) * 32'(m[2]);
      s1_zz_in    = 32'(m[3]) * 32'(m[3]);
      s1_xy_in    = 32'(m[1]) * 32'(m[2]);
      s1_xz_in    = 32'(m[1]) * 32'(m[3]);
      s1_yz_in    = 32'(m[2]) * 32'(m[3]);
      s1_xw_in    = 32'(m[1]) * 32'(m[0]);
      s1_yw_in    = 32'(m[2]) * 32'(m[0]);
      s1_zw_in    = 32'(m[3]) * 32'(m[0]);
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            s1_mq_in[i][j] = 32'(m[i]) * 32'(s0_q_ff[j]);
         end
      end
   end

   // Stage 2: rotation matrix entries in Q2.28 and p = m * q.
   always_comb begin
      s2_valid_in    = s1_valid_ff;
      s2_stamp_in    = s1_stamp_ff;
      s2_gyro_in     = s1_gyro_ff;
      s2_accel_in    = s1_accel_ff;
      s2_rm_in[0][0] = imufr_pkg::R_ONE - ((s1_yy_ff + s1_zz_ff) <<< 1);
      s2_rm_in[0][1] = (s1_xy_ff - s1_zw_ff) <<< 1;
      s2_rm_in[0][2] = (s1_xz_ff + s1_yw_ff) <<< 1;
      s2_rm_in[1][0] = (s1_xy_ff + s1_zw_ff) <<< 1;
      s2_rm_in[1][1] = imufr_pkg::R_ONE - ((s1_xx_ff + s1_zz_ff) <<< 1);
      s2_rm_in[1][2] = (s1_yz_ff - s1_xw_ff) <<< 1;
      s2_rm_in[2][0] = (s1_xz_ff - s1_yw_ff) <<< 1;
      s2_rm_in[2][1] = (s1_yz_ff + s1_xw_ff) <<< 1;
      s2_rm_in[2][2] = imufr_pkg::R_ONE - ((s1_xx_ff + s1_yy_ff) <<< 1);
      s2_p_in[0] = s1_mq_ff[0][0] - s1_mq_ff[1][1] - s1_mq_ff[2][2] - s1_mq_ff[3][3];
      s2_p_in[1] = s1_mq_ff[0][1] + s1_mq_ff[1][0] + s1_mq_ff[2][3] - s1_mq_ff[3][2];
      s2_p_in[2] = s1_mq_ff[0][2] - s1_mq_ff[1][3] + s1_mq_ff[2][0] + s1_mq_ff[3][1];
      s2_p_in[3] = s1_mq_ff[0][3] + s1_mq_ff[1][2] - s1_mq_ff[2][1] + s1_mq_ff[3][0];
   end

   // Stage 3: 32x32 products for the vectors, 32x16 products for p * m.
   always_comb begin
      s3_valid_in = s2_valid_ff;
      s3_stamp_in = s2_stamp_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s3_gp_in[i][j] = 64'(s2_rm_ff[i][j]) * 64'(s2_gyro_ff[j]);
            s3_ap_in[i][j] = 64'(s2_rm_ff[i][j]) * 64'(s2_accel_ff[j]);
         end
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            s3_pm_in[i][j] = 48'(s2_p_ff[i]) * 48'(m[j]);
         end
      end
   end

   // Stage 4: sums, rounding and saturation into the output register.
   // The conjugate's signs are folded into the sums of p * m.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         gsum[i] = s3_gp_ff[i][0] + s3_gp_ff[i][1] + s3_gp_ff[i][2];
         asum[i] = s3_ap_ff[i][0] + s3_ap_ff[i][1] + s3_ap_ff[i][2];
      end
      osum[0] = s3_pm_ff[0][0] + s3_pm_ff[1][1] + s3_pm_ff[2][2] + s3_pm_ff[3][3];
      osum[1] = s3_pm_ff[1][0] - s3_pm_ff[0][1] - s3_pm_ff[2][3] + s3_pm_ff[3][2];
      osum[2] = s3_pm_ff[2][0] - s3_pm_ff[0][2] + s3_pm_ff[1][3] - s3_pm_ff[3][1];
      osum[3] = s3_pm_ff[3][0] - s3_pm_ff[0][3] - s3_pm_ff[1][2] + s3_pm_ff[2][1];

      rsp_valid_in             = s3_valid_ff;
      rsp_data_in.out_stamp    = s3_stamp_ff;
      rsp_data_in.out_gyro_x   = round_vec(gsum[0]);
      rsp_data_in.out_gyro_y   = round_vec(gsum[1]);
      rsp_data_in.out_gyro_z   = round_vec(gsum[2]);
      rsp_data_in.out_accel_x  = round_vec(asum[0]);
      rsp_data_in.out_accel_y  = round_vec(asum[1]);
      rsp_data_in.out_accel_z  = round_vec(asum[2]);
      rsp_data_in.out_orient_w = round_quat(osum[0]);
      rsp_data_in.out_orient_x = round_quat(osum[1]);
      rsp_data_in.out_orient_y = round_quat(osum[2]);
      rsp_data_in.out_orient_z = round_quat(osum[3]);
   end

   // Valid bits of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers of the pipeline.
   always_ff @(posedge clock) begin
      s0_stamp_ff <= s0_stamp_in;
      s0_gyro_ff  <= s0_gyro_in;
      s0_accel_ff <= s0_accel_in;
      s0_q_ff     <= s0_q_in;
      s1_stamp_ff <= s1_stamp_in;
      s1_gyro_ff  <= s1_gyro_in;
      s1_accel_ff <= s1_accel_in;
      s1_xx_ff    <= s1_xx_in;
      s1_yy_ff    <= s1_yy_in;
      s1_zz_ff    <= s1_zz_in;
      s1_xy_ff    <= s1_xy_in;
      s1_xz_ff    <= s1_xz_in;
      s1_yz_ff    <= s1_yz_in;
      s1_xw_ff    <= s1_xw_in;
      s1_yw_ff    <= s1_yw_in;
      s1_zw_ff    <= s1_zw_in;
      s1_mq_ff    <= s1_mq_in;
      s2_stamp_ff <= s2_stamp_in;
      s2_gyro_ff  <= s2_gyro_in;
      s2_accel_ff <= s2_accel_in;
      s2_rm_ff    <= s2_rm_in;
      s2_p_ff     <= s2_p_in;
      s3_stamp_ff <= s3_stamp_in;
      s3_gp_ff    <= s3_gp_in;
      s3_ap_ff    <= s3_ap_in;
      s3_pm_ff    <= s3_pm_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // Every response traces back to an earlier request.
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 5))
      else $error("response without a matching request");

   // The timestamp travels the pipeline unchanged.
   a_stamp_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_stamp == $past(req_data.stamp, 5)))
      else $error("timestamp changed in the pipeline");

   // The orientation parts stay within the saturation bounds.
   a_orient_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_orient_w <= imufr_pkg::Q_ONE)
                 && (rsp_data.out_orient_w >= imufr_pkg::Q_MINUS_ONE)
                 && (rsp_data.out_orient_x <= imufr_pkg::Q_ONE)
                 && (rsp_data.out_orient_x >= imufr_pkg::Q_MINUS_ONE)
                 && (rsp_data.out_orient_y <= imufr_pkg::Q_ONE)
                 && (rsp_data.out_orient_y >= imufr_pkg::Q_MINUS_ONE)
                 && (rsp_data.out_orient_z <= imufr_pkg::Q_ONE)
                 && (rsp_data.out_orient_z >= imufr_pkg::Q_MINUS_ONE))
      else $error("orientation part outside its saturation range");
`endif

endmodule

[bench/imu_frame_rotation_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_rotation_test: self-checking bench for the IMU frame rotation block
// Feeds IMU samples through the request channel under a series of mounting
// quaternions and predicts every body-frame response in exact integer
// arithmetic. Each response is compared field by field with the oldest
// prediction. Random idle gaps on the request side shift samples against the
// pipeline stages.
// ----------------------------------------------------------------------------
module imu_frame_rotation_test;

   localparam int IDLE_LIMIT      = 2000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int NUM_PHASES      = 9;

   typedef struct {
      longint w;
      longint x;
      longint y;
      longint z;
   } quat_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     start     = 1'b0;
   logic                     busy;
   imufr_pkg::imufr_req_type req_data  = '0;
   logic                     rsp_valid;
   imufr_pkg::imufr_rsp_type rsp_data;
   logic                     csr_we    = 1'b0;
   logic [1:0]               csr_index = imufr_pkg::CSR_MOUNT_W;
   logic [15:0]              csr_wdata = '0;

   // Samples waiting to be sent, and body-frame results still to come back.
   imufr_pkg::imufr_req_type sensor_samples[$];
   imufr_pkg::imufr_rsp_type expected_body_samples[$];

   // Mounting quaternion as the block should hold it.
   logic [15:0] mount_regs [4];

   int idle_left   = 0;
   int idle_cycles = 0;
   int error_count = 0;
   int n_samples   = 0;
   int n_checked   = 0;
   int n_settings  = 1;
   bit no_idle     = 1'b0;

   imu_frame_rotation i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Fixed-point helpers of the prediction
   // ------------------------------------------------------------------

   // Quaternion parts are limited to [-1.0, 1.0] before use.
   function automatic longint clamp_unit(input longint v);
      if (v > longint'(imufr_pkg::Q_ONE)) return longint'(imufr_pkg::Q_ONE);
      if (v < longint'(imufr_pkg::Q_MINUS_ONE)) return longint'(imufr_pkg::Q_MINUS_ONE);
      return v;
   endfunction

   // Drop 28 fraction bits, rounding half up, and saturate to Q16.16.
   function automatic logic [31:0] round_vec(input longint v);
      longint t;
      t = (v + imufr_pkg::VEC_HALF) >>> 28;
      if (t > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (t < -64'sd2147483648) return 32'h8000_0000;
      return 32'(t);
   endfunction

   // Same rounding, saturated to the Q1.14 unit range.
   function automatic logic [15:0] round_part(input longint v);
      longint t;
      t = (v + imufr_pkg::VEC_HALF) >>> 28;
      if (t > longint'(imufr_pkg::Q_ONE)) return imufr_pkg::Q_ONE;
      if (t < longint'(imufr_pkg::Q_MINUS_ONE)) return imufr_pkg::Q_MINUS_ONE;
      return 16'(t);
   endfunction

   function automatic quat_type quat_mul(input quat_type a, input quat_type b);
      quat_type r;
      r.w = a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z;
      r.x = a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y;
      r.y = a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x;
      r.z = a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w;
      return r;
   endfunction

   // Body-frame sample for one sensor-frame sample under the current mount.
   function automatic imufr_pkg::imufr_rsp_type rotate_sample(
      input imufr_pkg::imufr_req_type s);
      quat_type                 mnt;
      quat_type                 mnt_conj;
      quat_type                 ori;
      quat_type                 turned;
      longint                   rot [3][3];
      longint                   gyro [3];
      longint                   accel [3];
      longint                   sum_g;
      longint                   sum_a;
      logic [31:0]              out_g [3];
      logic [31:0]              out_a [3];
      imufr_pkg::imufr_rsp_type r;

      mnt.w = clamp_unit($signed(mount_regs[imufr_pkg::CSR_MOUNT_W]));
      mnt.x = clamp_unit($signed(mount_regs[imufr_pkg::CSR_MOUNT_X]));
      mnt.y = clamp_unit($signed(mount_regs[imufr_pkg::CSR_MOUNT_Y]));
      mnt.z = clamp_unit($signed(mount_regs[imufr_pkg::CSR_MOUNT_Z]));

      // Rotation matrix of the mount, exact in Q2.28.
      rot[0][0] = longint'(imufr_pkg::R_ONE) - 2 * (mnt.y * mnt.y + mnt.z * mnt.z);
      rot[0][1] = 2 * (mnt.x * mnt.y - mnt.z * mnt.w);
      rot[0][2] = 2 * (mnt.x * mnt.z + mnt.y * mnt.w);
      rot[1][0] = 2 * (mnt.x * mnt.y + mnt.z * mnt.w);
      rot[1][1] = longint'(imufr_pkg::R_ONE) - 2 * (mnt.x * mnt.x + mnt.z * mnt.z);
      rot[1][2] = 2 * (mnt.y * mnt.z - mnt.x * mnt.w);
      rot[2][0] = 2 * (mnt.x * mnt.z - mnt.y * mnt.w);
      rot[2][1] = 2 * (mnt.y * mnt.z + mnt.x * mnt.w);
      rot[2][2] = longint'(imufr_pkg::R_ONE) - 2 * (mnt.x * mnt.x + mnt.y * mnt.y);

      gyro[0]  = $signed(s.gyro_x);
      gyro[1]  = $signed(s.gyro_y);
      gyro[2]  = $signed(s.gyro_z);
      accel[0] = $signed(s.accel_x);
      accel[1] = $signed(s.accel_y);
      accel[2] = $signed(s.accel_z);

      for (int i = 0; i < 3; i++) begin
         sum_g = 0;
         sum_a = 0;
         for (int j = 0; j < 3; j++) begin
            sum_g += rot[i][j] * gyro[j];
            sum_a += rot[i][j] * accel[j];
         end
         out_g[i] = round_vec(sum_g);
         out_a[i] = round_vec(sum_a);
      end

      // Orientation becomes mount * sample * conj(mount).
      ori.w = clamp_unit($signed(s.orient_w));
      ori.x = clamp_unit($signed(s.orient_x));
      ori.y = clamp_unit($signed(s.orient_y));
      ori.z = clamp_unit($signed(s.orient_z));
      mnt_conj.w = mnt.w;
      mnt_conj.x = -mnt.x;
      mnt_conj.y = -mnt.y;
      mnt_conj.z = -mnt.z;
      turned = quat_mul(quat_mul(mnt, ori), mnt_conj);

      r.out_stamp    = s.stamp;
      r.out_gyro_x   = out_g[0];
      r.out_gyro_y   = out_g[1];
      r.out_gyro_z   = out_g[2];
      r.out_accel_x  = out_a[0];
      r.out_accel_y  = out_a[1];
      r.out_accel_z  = out_a[2];
      r.out_orient_w = round_part(turned.w);
      r.out_orient_x = round_part(turned.x);
      r.out_orient_y = round_part(turned.y);
      r.out_orient_z = round_part(turned.z);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
   endtask

   task automatic check_response(input imufr_pkg::imufr_rsp_type got,
                                 input imufr_pkg::imufr_rsp_type want);
      check_field("out_stamp", got.out_stamp, want.out_stamp);
      check_field("out_gyro_x", got.out_gyro_x, want.out_gyro_x);
      check_field("out_gyro_y", got.out_gyro_y, want.out_gyro_y);
      check_field("out_gyro_z", got.out_gyro_z, want.out_gyro_z);
      check_field("out_accel_x", got.out_accel_x, want.out_accel_x);
      check_field("out_accel_y", got.out_accel_y, want.out_accel_y);
      check_field("out_accel_z", got.out_accel_z, want.out_accel_z);
      check_field("out_orient_w", 32'(got.out_orient_w), 32'(want.out_orient_w));
      check_field("out_orient_x", 32'(got.out_orient_x), 32'(want.out_orient_x));
      check_field("out_orient_y", 32'(got.out_orient_y), 32'(want.out_orient_y));
      check_field("out_orient_z", 32'(got.out_orient_z), 32'(want.out_orient_z));
   endtask

   // Monitor: predicts each accepted transaction, checks each response and
   // tracks register writes. The prediction is pushed before the response
   // check so that an answer in the same cycle would still find its expectation.
   always @(posedge clock) begin
      if (reset) begin
         mount_regs[imufr_pkg::CSR_MOUNT_W] = imufr_pkg::Q_ONE;
         mount_regs[imufr_pkg::CSR_MOUNT_X] = '0;
         mount_regs[imufr_pkg::CSR_MOUNT_Y] = '0;
         mount_regs[imufr_pkg::CSR_MOUNT_Z] = '0;
      end else begin
         if (start && !busy) begin
            expected_body_samples.push_back(rotate_sample(req_data));
            n_samples++;
         end
         if (rsp_valid) begin
            if (expected_body_samples.size() == 0) begin
               report_mismatch("response with no sample outstanding");
            end else begin
               check_response(rsp_data, expected_body_samples.pop_front());
               n_checked++;
            end
         end
         if (csr_we)
            mount_regs[csr_index] = csr_wdata;
      end
   end

   // ------------------------------------------------------------------
   // Driver: sends queued samples with random idle gaps between them.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : driver
      int unsigned pick;
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else if (!start || !busy) begin
         // Any transaction on the port was taken at this edge.
         if (idle_left > 0 || sensor_samples.size() == 0) begin
            start <= 1'b0;
            if (idle_left > 0)
               idle_left <= idle_left - 1;
         end else begin
            start    <= 1'b1;
            req_data <= sensor_samples.pop_front();
            // Now and then switch between gapped and back-to-back traffic.
            if ($urandom_range(0, 49) == 0)
               no_idle <= !no_idle;
            pick = $urandom_range(0, 99);
            if (no_idle || pick < 55)
               idle_left <= 0;
            else if (pick < 88)
               idle_left <= $urandom_range(1, 3);
            else
               idle_left <= $urandom_range(4, 30);
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired after %0d quiet cycles", IDLE_LIMIT);
         $display("imu_frame_rotation_test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Waits until every sample has been sent and answered.
   task automatic wait_drained();
      @(negedge clock);
      while (sensor_samples.size() != 0 || start || expected_body_samples.size() != 0)
         @(negedge clock);
   endtask

   // Loads a new mounting quaternion while the pipeline is empty.
   task automatic set_mount(input logic [15:0] w, input logic [15:0] x,
                            input logic [15:0] y, input logic [15:0] z);
      logic [1:0]  idx [4];
      logic [15:0] val [4];
      idx = '{imufr_pkg::CSR_MOUNT_W, imufr_pkg::CSR_MOUNT_X,
              imufr_pkg::CSR_MOUNT_Y, imufr_pkg::CSR_MOUNT_Z};
      val = '{w, x, y, z};
      wait_drained();
      for (int i = 0; i < 4; i++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      n_settings++;
   endtask

   function automatic logic [31:0] rand_vec();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return 32'(int'($urandom_range(0, 4000)) - 2000);
         4:       return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] rand_part();
      case ($urandom_range(0, 7))
         0:       return imufr_pkg::Q_ONE;
         1:       return imufr_pkg::Q_MINUS_ONE;
         2:       return 16'($urandom);
         default: return 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic imufr_pkg::imufr_req_type make_sample(
      input logic [31:0] stamp,
      input logic [31:0] gx, input logic [31:0] gy, input logic [31:0] gz,
      input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
      input logic [15:0] ow, input logic [15:0] ox,
      input logic [15:0] oy, input logic [15:0] oz);
      imufr_pkg::imufr_req_type s;
      s.stamp    = stamp;
      s.gyro_x   = gx;
      s.gyro_y   = gy;
      s.gyro_z   = gz;
      s.accel_x  = ax;
      s.accel_y  = ay;
      s.accel_z  = az;
      s.orient_w = ow;
      s.orient_x = ox;
      s.orient_y = oy;
      s.orient_z = oz;
      return s;
   endfunction

   initial begin : stimulus
      imufr_pkg::imufr_req_type s;
      real                      ra;
      real                      rb;
      real                      rc;
      real                      rd;
      real                      norm;
      localparam logic [31:0] VMAX = 32'h7FFF_FFFF;
      localparam logic [31:0] VMIN = 32'h8000_0000;
      localparam logic [15:0] QP   = imufr_pkg::Q_ONE;
      localparam logic [15:0] QN   = imufr_pkg::Q_MINUS_ONE;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: ;  // identity mount straight out of reset
            1: set_mount(QP, QP, QP, QP);            // non-unit, large gain
            2: set_mount(QN, QN, QN, QN);
            3: set_mount(16'h7FFF, 16'h8000, 16'h4001, 16'hBFFF);  // clamped
            4: set_mount(16'd11585, 16'd0, 16'd0, 16'd11585);      // 90 deg about z
            5: set_mount(16'd0, QP, 16'd0, 16'd0);                 // 180 deg about x
            default: begin
               // Random unit mount, truncated to Q1.14.
               ra = real'(int'($urandom_range(0, 2000)) - 1000);
               rb = real'(int'($urandom_range(0, 2000)) - 1000);
               rc = real'(int'($urandom_range(0, 2000)) - 1000);
               rd = real'(int'($urandom_range(0, 2000)) - 1000);
               norm = $sqrt(ra * ra + rb * rb + rc * rc + rd * rd);
               if (norm < 1.0) begin
                  ra   = 1.0;
                  norm = 1.0;
               end
               set_mount(16'($rtoi(16384.0 * ra / norm)), 16'($rtoi(16384.0 * rb / norm)),
                         16'($rtoi(16384.0 * rc / norm)), 16'($rtoi(16384.0 * rd / norm)));
            end
         endcase

         @(negedge clock);

         // Directed samples under the identity and the large-gain mounts.
         if (ph <= 1) begin
            sensor_samples.push_back(make_sample(32'h0, 0, 0, 0, 0, 0, 0,
                                                 16'd0, 16'd0, 16'd0, 16'd0));
            sensor_samples.push_back(make_sample(32'hFFFF_FFFF, VMAX, VMAX, VMAX,
                                                 VMAX, VMAX, VMAX, QP,
                                                 16'd0, 16'd0, 16'd0));
            sensor_samples.push_back(make_sample(32'h8000_0000, VMIN, VMIN, VMIN,
                                                 VMIN, VMIN, VMIN, QN,
                                                 16'd0, 16'd0, 16'd0));
            sensor_samples.push_back(make_sample(32'h5A5A_A5A5, VMAX, VMIN, VMAX,
                                                 VMIN, VMAX, VMIN, QP, QP, QP, QP));
            sensor_samples.push_back(make_sample(32'hA5A5_5A5A, VMIN, VMAX, VMIN,
                                                 VMAX, VMIN, VMAX, QN, QN, QN, QN));
            // Orientation parts beyond one are clamped before use.
            sensor_samples.push_back(make_sample(32'h1, 32'h0001_0000, 0, 0, 0, 0, 0,
                                                 16'h7FFF, 16'h8000, 16'h4001, 16'hBFFF));
            // Smallest nonzero vectors exercise the rounding.
            sensor_samples.push_back(make_sample(32'h2, 1, -1, 1, -1, 1, -1,
                                                 16'd0, 16'd0, 16'd0, QP));
            sensor_samples.push_back(make_sample(32'h3, 32'h0001_0000, 32'hFFFF_0000,
                                                 32'h0000_8000, 32'h0000_8000,
                                                 32'hFFFF_8000, 32'h0001_0000,
                                                 16'd11585, 16'd0, 16'd11585, 16'd0));
            sensor_samples.push_back(make_sample(32'h4, 32'h4000_0000, 32'hC000_0000,
                                                 32'h4000_0000, 32'hC000_0000,
                                                 32'h4000_0000, 32'hC000_0000,
                                                 16'd0, 16'd0, QP, 16'd0));
            sensor_samples.push_back(make_sample(32'h7FFF_FFFF, 0, 0, VMAX, VMIN, 0, 0,
                                                 16'd0, QN, 16'd0, 16'd0));
         end

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            s.stamp    = $urandom;
            s.gyro_x   = rand_vec();
            s.gyro_y   = rand_vec();
            s.gyro_z   = rand_vec();
            s.accel_x  = rand_vec();
            s.accel_y  = rand_vec();
            s.accel_z  = rand_vec();
            s.orient_w = rand_part();
            s.orient_x = rand_part();
            s.orient_y = rand_part();
            s.orient_z = rand_part();
            sensor_samples.push_back(s);
         end
      end

      // Let the pipeline empty and the bench stay quiet before the report.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Rotated %0d IMU samples under %0d mounting quaternions;", n_samples,
               n_settings);
      $display("%0d responses checked, %0d mismatches.", n_checked, error_count);
      if (error_count == 0)
         $display("imu_frame_rotation_test passed");
      else
         $display("imu_frame_rotation_test failed");
      $finish;
   end

endmodule
